[rtl/rpv_pkg.sv]
// shared types, codes and character constants for the relative path validator
package rpv_pkg;

  // verdict codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FORMAT = 2'd1;
  localparam logic [1:0] ST_LIMIT  = 2'd2;

  // register indexes
  localparam logic [1:0] CFG_MAX_PATH_LENGTH      = 2'd0;
  localparam logic [1:0] CFG_MAX_COMPONENT_LENGTH = 2'd1;
  localparam logic [1:0] CFG_MAX_COMPONENTS       = 2'd2;
  localparam logic [1:0] CFG_ALLOW_HIDDEN         = 2'd3;

  localparam int unsigned CFG_DATA_W = 16;

  // register reset values
  localparam logic [15:0] RST_MAX_PATH_LENGTH      = 16'd4096;
  localparam logic [15:0] RST_MAX_COMPONENT_LENGTH = 16'd255;
  localparam logic [7:0]  RST_MAX_COMPONENTS       = 8'd32;

  // characters of interest
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DEL    = 8'h7F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_DOT    = 8'h2E;

  localparam int unsigned CNT_W = 17;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef struct packed {
    logic [CNT_W-1:0] byte_count;
    logic [CNT_W-1:0] comp_len;
    logic [7:0]       comp_count;
    logic             first_dot;
    logic             second_dot;
    logic [1:0]       first_error;
  } rpv_state_t;

  typedef struct packed {
    logic [15:0] max_path_length;
    logic [15:0] max_component_length;
    logic [7:0]  max_components;
    logic        allow_hidden;
  } rpv_cfg_t;

  function automatic rpv_state_t rpv_state_clear();
    rpv_state_t s;
    s.byte_count  = '0;
    s.comp_len    = '0;
    s.comp_count  = '0;
    s.first_dot   = 1'b0;
    s.second_dot  = 1'b0;
    s.first_error = ST_OK;
    return s;
  endfunction

endpackage

[rtl/rpv_cfg.sv]
// configuration register file for the relative path validator
module rpv_cfg
  import rpv_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output rpv_cfg_t              cfg
);

  rpv_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_path_length      <= RST_MAX_PATH_LENGTH;
      cfg_r.max_component_length <= RST_MAX_COMPONENT_LENGTH;
      cfg_r.max_components       <= RST_MAX_COMPONENTS;
      cfg_r.allow_hidden         <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_PATH_LENGTH:      cfg_r.max_path_length      <= cfg_wdata;
        CFG_MAX_COMPONENT_LENGTH: cfg_r.max_component_length <= cfg_wdata;
        CFG_MAX_COMPONENTS:       cfg_r.max_components       <= cfg_wdata[7:0];
        CFG_ALLOW_HIDDEN:         cfg_r.allow_hidden         <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[rtl/rpv_step.sv]
// next-state and verdict logic for one path byte
module rpv_step
  import rpv_pkg::*;
(
  input  rpv_state_t state,
  input  rpv_cfg_t   cfg,
  input  logic [7:0] path_byte,
  output rpv_state_t state_nxt,
  output logic       is_term,
  output logic [1:0] status
);

  logic [1:0] close_st;
  logic       byte_bad;
  logic [1:0] err_eff;

  // verdict on the component being closed
  always_comb begin
    priority if (state.comp_len == '0) begin
      close_st = ST_FORMAT;
    end else if (state.comp_len > {1'b0, cfg.max_component_length}) begin
      close_st = ST_LIMIT;
    end else if (state.first_dot && ((state.comp_len == 17'd1) ||
                 ((state.comp_len == 17'd2) && state.second_dot))) begin
      close_st = ST_FORMAT;
    end else if (state.first_dot && !cfg.allow_hidden) begin
      close_st = ST_FORMAT;
    end else if (state.comp_count == cfg.max_components) begin
      close_st = ST_LIMIT;
    end else begin
      close_st = ST_OK;
    end
  end

  assign is_term  = (path_byte == CH_NUL);
  assign byte_bad = (path_byte < CH_SPACE) || (path_byte == CH_DEL) ||
                    (path_byte == CH_BSLASH) || (path_byte == CH_COLON);
  assign err_eff  = (state.first_error == ST_OK) ? close_st : state.first_error;
  assign status   = (state.byte_count > {1'b0, cfg.max_path_length}) ? ST_LIMIT : err_eff;

  always_comb begin
    state_nxt = state;
    if (is_term) begin
      state_nxt = rpv_state_clear();
    end else begin
      if (state.byte_count != CNT_MAX) begin
        state_nxt.byte_count = state.byte_count + 17'd1;
      end
      if (state.first_error == ST_OK) begin
        if (byte_bad) begin
          state_nxt.first_error = ST_FORMAT;
        end else if (path_byte == CH_SLASH) begin
          state_nxt.first_error = close_st;
          if (close_st == ST_OK) begin
            state_nxt.comp_count = state.comp_count + 8'd1;
            state_nxt.comp_len   = '0;
            state_nxt.first_dot  = 1'b0;
            state_nxt.second_dot = 1'b0;
          end
        end else begin
          if (state.comp_len == '0) begin
            state_nxt.first_dot = (path_byte == CH_DOT);
          end else if (state.comp_len == 17'd1) begin
            state_nxt.second_dot = (path_byte == CH_DOT);
          end
          if (state.comp_len != CNT_MAX) begin
            state_nxt.comp_len = state.comp_len + 17'd1;
          end
        end
      end
    end
  end

endmodule

[rtl/relative_path_validator.sv]
// relative path validator top level: path state, step logic and result register
// status word is registered, valid in the cycle after the terminating zero byte is accepted
// throughput: one path byte per cycle; only a full, unread result register stalls input
// path state lives in a single register bank updated by one pass of step logic per byte
// reset (synchronous, active low) clears path state and result valid, loads register defaults
module relative_path_validator
  import rpv_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // byte input
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_path_byte,
  // status output
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_status,
  // configuration writes
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  rpv_cfg_t   cfg;
  rpv_state_t state_r;
  rpv_state_t state_nxt;
  logic       is_term;
  logic [1:0] status;
  logic       in_fire;
  logic       out_valid_r;
  logic [1:0] out_status_r;

  // register file
  rpv_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // per-byte update and verdict at the terminator
  rpv_step u_step (
    .state     (state_r),
    .cfg       (cfg),
    .path_byte (in_path_byte),
    .state_nxt (state_nxt),
    .is_term   (is_term),
    .status    (status)
  );

  // take a byte whenever the result register is empty or being drained
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // path state: counters, dot flags, first error
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rpv_state_clear();
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  // result register, loaded only by a terminator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && is_term) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && is_term) begin
      out_status_r <= status;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;

`ifndef SYNTHESIS
  // a terminator leaves the path state fully cleared
  a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_path_byte == CH_NUL) |=>
      (state_r.byte_count == '0) && (state_r.comp_len == '0) &&
      (state_r.comp_count == '0) && (state_r.first_error == ST_OK))
    else $error("path state not cleared after terminator");

  // a terminator always produces a result word next cycle
  a_term_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_path_byte == CH_NUL) |=> out_valid)
    else $error("terminator produced no result word");

  // status word is never the reserved code
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK) || (out_status == ST_FORMAT) ||
                  (out_status == ST_LIMIT))
    else $error("reserved status code");

  // an error once recorded holds until the terminator
  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_path_byte != CH_NUL) && (state_r.first_error != ST_OK) |=>
      state_r.first_error == $past(state_r.first_error))
    else $error("first error overwritten mid-path");
`endif

endmodule

[verif/relative_path_validator_checker.sv]
// checker for the relative path validator: mirrors registers, predicts each status word, compares
module relative_path_validator_checker
  import rpv_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [7:0]            in_path_byte,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [1:0]            out_status,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int unsigned           fail_count,
  output int unsigned           status_pending
);

  // register mirror
  logic [15:0] lim_path;
  logic [15:0] lim_comp;
  logic [7:0]  lim_depth;
  logic        hidden_ok;

  // per-path scan state
  logic [CNT_W-1:0] path_len;
  logic [CNT_W-1:0] comp_len;
  logic [8:0]       comp_cnt;
  logic             lead_dot;
  logic             next_dot;
  logic [1:0]       err;

  logic [1:0] status_q[$];

  function automatic void clear_scan();
    path_len = '0;
    comp_len = '0;
    comp_cnt = '0;
    lead_dot = 1'b0;
    next_dot = 1'b0;
    err      = ST_OK;
  endfunction

  // verdict on the component just closed, counts it when accepted
  function automatic logic [1:0] close_component();
    if (comp_len == '0) return ST_FORMAT;
    if (comp_len > {1'b0, lim_comp}) return ST_LIMIT;
    if (lead_dot && (comp_len == 17'd1 || (comp_len == 17'd2 && next_dot))) return ST_FORMAT;
    if (lead_dot && !hidden_ok) return ST_FORMAT;
    if (comp_cnt == {1'b0, lim_depth}) return ST_LIMIT;
    comp_cnt = comp_cnt + 9'd1;
    comp_len = '0;
    lead_dot = 1'b0;
    next_dot = 1'b0;
    return ST_OK;
  endfunction

  task automatic scan_byte(input logic [7:0] b);
    logic [1:0] verdict;
    if (b == CH_NUL) begin
      if (err == ST_OK) err = close_component();
      verdict = (path_len > {1'b0, lim_path}) ? ST_LIMIT : err;
      status_q.push_back(verdict);
      clear_scan();
    end else begin
      if (path_len != CNT_MAX) path_len = path_len + 17'd1;
      if (err == ST_OK) begin
        if (b < CH_SPACE || b == CH_DEL || b == CH_BSLASH || b == CH_COLON) begin
          err = ST_FORMAT;
        end else if (b == CH_SLASH) begin
          err = close_component();
        end else begin
          if (comp_len == '0) lead_dot = (b == CH_DOT);
          else if (comp_len == 17'd1) next_dot = (b == CH_DOT);
          if (comp_len != CNT_MAX) comp_len = comp_len + 17'd1;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      lim_path  = RST_MAX_PATH_LENGTH;
      lim_comp  = RST_MAX_COMPONENT_LENGTH;
      lim_depth = RST_MAX_COMPONENTS;
      hidden_ok = 1'b0;
      clear_scan();
      status_q.delete();
      status_pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAX_PATH_LENGTH:      lim_path  = cfg_wdata[15:0];
          CFG_MAX_COMPONENT_LENGTH: lim_comp  = cfg_wdata[15:0];
          CFG_MAX_COMPONENTS:       lim_depth = cfg_wdata[7:0];
          CFG_ALLOW_HIDDEN:         hidden_ok = cfg_wdata[0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (status_q.size() == 0) begin
          $error("out_status: expected none, actual %0d", out_status);
          fail_count <= fail_count + 1;
        end else if (out_status !== status_q[0]) begin
          $error("out_status: expected %0d, actual %0d", status_q[0], out_status);
          fail_count <= fail_count + 1;
          void'(status_q.pop_front());
        end else begin
          void'(status_q.pop_front());
        end
      end
      if (in_valid && in_ready) scan_byte(in_path_byte);
      status_pending <= status_q.size();
    end
  end

endmodule

[verif/relative_path_validator_tb.sv]
// testbench top for the relative path validator: clock, reset, path stimulus and verdict
module relative_path_validator_tb
  import rpv_pkg::*;
();

  // rough number of path bytes to send before stopping
  localparam int unsigned ITEM_TARGET = 1000;
  // cycles with no word moving on any port before the run is called hung;
  // worst honest case is a sender gap plus a receiver stall
  localparam int unsigned STALL_LIMIT = 1000;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [7:0]            in_path_byte;
  logic                  out_valid;
  logic                  out_ready;
  logic [1:0]            out_status;
  logic                  cfg_we;
  logic [1:0]            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int unsigned fail_count;
  int unsigned status_pending;

  // sender pacing
  int unsigned bytes_sent;
  int unsigned burst_left;
  logic        steady;

  // copy of the limits, only used to shape paths around them
  logic [15:0] cur_path_lim;
  logic [15:0] cur_comp_lim;
  logic [7:0]  cur_depth_lim;
  logic        cur_hidden;

  // receiver stall pattern
  logic [15:0] stall_pat;
  int unsigned pat_age;

  int unsigned idle_cycles;

  relative_path_validator i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_path_byte (in_path_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  relative_path_validator_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_path_byte   (in_path_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .fail_count     (fail_count),
    .status_pending (status_pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver: rotates a stall pattern, reloaded now and then;
  // bit 0 of a reload is forced high so no stall lasts a whole turn of the pattern
  initial begin
    out_ready = 1'b0;
    stall_pat = 16'hFFFF;
    pat_age   = 0;
    forever begin
      @(negedge clk);
      if (pat_age == 0) begin
        pat_age = $urandom_range(50, 300);
        if ($urandom_range(0, 3) == 0) stall_pat = 16'hFFFF;
        else stall_pat = 16'($urandom) | 16'h0001;
      end else begin
        pat_age--;
        stall_pat = {stall_pat[0], stall_pat[15:1]};
      end
      out_ready <= stall_pat[0];
    end
  end

  // watchdog: any word moved on any port, or reset, clears the count
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("relative_path_validator: mismatch");
      $finish;
    end
  end

  // one path byte: raise valid at the falling edge, hold until taken,
  // then maybe drop valid for a gap once the burst runs out
  task automatic push_byte(input logic [7:0] b);
    @(negedge clk);
    in_valid     <= 1'b1;
    in_path_byte <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    if (!steady) begin
      if (burst_left == 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat ($urandom_range(0, 11)) @(negedge clk);
        burst_left = $urandom_range(0, 24);
      end else begin
        burst_left--;
      end
    end
  endtask

  // hold the sender until every status word is back and the last terminator
  // has fully cleared the pipeline
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (status_pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_MAX_PATH_LENGTH:      cur_path_lim  = val[15:0];
      CFG_MAX_COMPONENT_LENGTH: cur_comp_lim  = val[15:0];
      CFG_MAX_COMPONENTS:       cur_depth_lim = val[7:0];
      CFG_ALLOW_HIDDEN:         cur_hidden    = val[0];
      default: ;
    endcase
  endtask

  // narrow registers get junk in the upper bits, which must be masked off
  task automatic apply_limits(input logic [15:0] p, input logic [15:0] c,
                              input logic [7:0] d, input logic h);
    wait_idle();
    write_reg(CFG_MAX_PATH_LENGTH, p);
    write_reg(CFG_MAX_COMPONENT_LENGTH, c);
    write_reg(CFG_MAX_COMPONENTS, {8'($urandom), d});
    write_reg(CFG_ALLOW_HIDDEN, {15'($urandom), h});
  endtask

  // any byte legal inside a name, high bytes and space included
  function automatic logic [7:0] name_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(32, 255));
    while (b == CH_DEL || b == CH_BSLASH || b == CH_COLON || b == CH_SLASH);
    return b;
  endfunction

  function automatic logic [7:0] bad_byte();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(1, 31));
      1:       return CH_DEL;
      2:       return CH_BSLASH;
      default: return CH_COLON;
    endcase
  endfunction

  // one whole path ending in the terminator; mostly well-formed names
  // sized around the current limits, the rest raw noise
  task automatic send_path();
    int unsigned ncomp;
    int unsigned len;
    int unsigned pick;
    int unsigned ok_len;
    int unsigned ok_depth;
    if ($urandom_range(0, 99) < 80) begin
      ok_len   = (cur_comp_lim == 0) ? 1 : ((cur_comp_lim < 8) ? cur_comp_lim : 8);
      ok_depth = (cur_depth_lim == 0) ? 1 : ((cur_depth_lim < 6) ? cur_depth_lim : 6);
      // now and then one component past the depth limit
      if ($urandom_range(0, 7) == 0 && cur_depth_lim < 8) ncomp = cur_depth_lim + 1;
      else ncomp = $urandom_range(1, ok_depth);
      // leading slash means an empty first component
      if ($urandom_range(0, 29) == 0) push_byte(CH_SLASH);
      for (int c = 0; c < ncomp; c++) begin
        if (c != 0) push_byte(CH_SLASH);
        pick = $urandom_range(0, 39);
        if (pick == 0) begin
          // empty component: no name bytes before the next slash or terminator
        end else if (pick == 1) begin
          push_byte(CH_DOT);
        end else if (pick == 2) begin
          push_byte(CH_DOT);
          push_byte(CH_DOT);
        end else if (pick < 6) begin
          // hidden name, dot then at least one more byte
          push_byte(CH_DOT);
          len = $urandom_range(1, ok_len);
          for (int k = 0; k < len; k++) push_byte(name_byte());
        end else begin
          // a few names one past the length limit
          if (pick < 8 && cur_comp_lim < 8) len = cur_comp_lim + 1;
          else len = $urandom_range(1, ok_len);
          for (int k = 0; k < len; k++) push_byte(name_byte());
        end
        if ($urandom_range(0, 39) == 0) push_byte(bad_byte());
      end
      // trailing slash leaves an empty last component
      if ($urandom_range(0, 29) == 0) push_byte(CH_SLASH);
    end else begin
      len = $urandom_range(0, 10);
      for (int k = 0; k < len; k++) begin
        pick = $urandom_range(0, 7);
        if (pick < 2) push_byte(CH_SLASH);
        else if (pick == 2) push_byte(CH_DOT);
        else push_byte(8'($urandom_range(1, 255)));
      end
    end
    push_byte(CH_NUL);
  endtask

  initial begin
    logic [7:0] intro[$];
    int unsigned phase_start;
    // empty, plain, lone slash, dot names, hidden, each rejected byte,
    // then a two-component name with a high byte and a space
    intro = '{CH_NUL,
              8'h61, CH_NUL,
              CH_SLASH, CH_NUL,
              CH_DOT, CH_NUL,
              CH_DOT, CH_DOT, CH_NUL,
              CH_DOT, 8'h68, CH_NUL,
              8'h01, CH_NUL,
              CH_DEL, CH_NUL,
              CH_BSLASH, CH_NUL,
              CH_COLON, CH_NUL,
              8'hFF, CH_SPACE, CH_SLASH, 8'h62, CH_NUL};

    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_path_byte  = '0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_MAX_PATH_LENGTH;
    cfg_wdata     = '0;
    bytes_sent    = 0;
    burst_left    = 0;
    steady        = 1'b0;
    cur_path_lim  = RST_MAX_PATH_LENGTH;
    cur_comp_lim  = RST_MAX_COMPONENT_LENGTH;
    cur_depth_lim = RST_MAX_COMPONENTS;
    cur_hidden    = 1'b0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed paths under the reset limits
    foreach (intro[i]) push_byte(intro[i]);

    for (int ph = 0; bytes_sent < ITEM_TARGET; ph++) begin
      case (ph)
        0: apply_limits(16'd40, 16'd6, 8'd4, 1'b1);        // tight, hidden allowed
        1: apply_limits(16'd0, 16'd0, 8'd0, 1'b0);         // everything at zero
        2: apply_limits(16'hFFFF, 16'hFFFF, 8'hFF, 1'b1);  // everything at the top
        3: apply_limits(16'd12, 16'd3, 8'd2, 1'b0);        // tight, hidden refused
        default: apply_limits(16'($urandom_range(0, 40)), 16'($urandom_range(0, 9)),
                              8'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
      endcase
      // about one phase in four runs flat out on the send side
      steady = ($urandom_range(0, 3) == 0);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < 90) begin
        send_path();
        if ($urandom_range(0, 19) == 0) wait_idle();
      end
    end

    // drain, then give the last word time to show up
    wait_idle();
    repeat (4) @(negedge clk);
    if (fail_count == 0) begin
      $display("relative_path_validator: match");
    end else begin
      $display("relative_path_validator: mismatch");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/rpv_pkg.sv
rtl/rpv_cfg.sv
rtl/rpv_step.sv
rtl/relative_path_validator.sv
verif/relative_path_validator_checker.sv
verif/relative_path_validator_tb.sv
